// ===== hw/rtl/slist_pkg.sv =====
`timescale 1ns / 1ps

package slist_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic              load_req;
    logic              do_insert;
    logic              do_remove;
    logic              load_result;
    logic [STAT_W-1:0] result_status;
  } slist_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] req_kind;
    logic              key_found;
    logic              store_full;
  } slist_stat_t;

endpackage

// ===== hw/rtl/slist_ctrl.sv =====
`timescale 1ns / 1ps

module slist_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  slist_pkg::slist_stat_t stat,
  output slist_pkg::slist_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_HOLD);

  always_comb begin
    state_next        = state;
    cmd               = '0;
    cmd.result_status = slist_pkg::STAT_MISSING;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.load_result = 1'b1;
        case (stat.req_kind)
          slist_pkg::KIND_INSERT: begin
            if (stat.store_full) begin
              cmd.result_status = slist_pkg::STAT_FULL;
            end else begin
              cmd.do_insert     = 1'b1;
              cmd.result_status = slist_pkg::STAT_DONE;
            end
          end
          slist_pkg::KIND_REMOVE: begin
            if (stat.key_found) begin
              cmd.do_remove     = 1'b1;
              cmd.result_status = slist_pkg::STAT_DONE;
            end
          end
          slist_pkg::KIND_SEARCH: begin
            if (stat.key_found) cmd.result_status = slist_pkg::STAT_DONE;
          end
          default: cmd.result_status = slist_pkg::STAT_MISSING;
        endcase
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/slist_datapath.sv =====
`timescale 1ns / 1ps

module slist_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [slist_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [slist_pkg::KEY_W-1:0]  in_value,
  input  slist_pkg::slist_cmd_t               cmd,
  output slist_pkg::slist_stat_t              stat,
  output logic [slist_pkg::STAT_W-1:0]        out_status,
  output logic signed [slist_pkg::KEY_W-1:0]  out_value,
  output logic [slist_pkg::CNT_W-1:0]         out_count
);

  logic signed [slist_pkg::KEY_W-1:0] entries [slist_pkg::CAPACITY];
  logic signed [slist_pkg::KEY_W-1:0] entries_next [slist_pkg::CAPACITY];
  logic [slist_pkg::CNT_W-1:0]        count;
  logic [slist_pkg::CNT_W-1:0]        count_next;
  logic [slist_pkg::KIND_W-1:0]       req_kind;
  logic signed [slist_pkg::KEY_W-1:0] req_value;

  // per-cell compare against the request key; cells at or above count are invalid
  logic [slist_pkg::CAPACITY-1:0] cell_valid;
  logic [slist_pkg::CAPACITY-1:0] cell_le;
  logic [slist_pkg::CAPACITY-1:0] cell_ge;
  logic [slist_pkg::CAPACITY-1:0] cell_eq;

  always_comb begin
    for (int i = 0; i < slist_pkg::CAPACITY; i++) begin
      cell_valid[i] = slist_pkg::CNT_W'(i) < count;
      cell_le[i]    = cell_valid[i] && (entries[i] <= req_value);
      cell_ge[i]    = cell_valid[i] && (entries[i] >= req_value);
      cell_eq[i]    = cell_valid[i] && (entries[i] == req_value);
    end
  end

  assign stat.req_kind   = req_kind;
  assign stat.key_found  = |cell_eq;
  assign stat.store_full = (count == slist_pkg::CNT_W'(slist_pkg::CAPACITY));

  // insert: cells holding keys <= value stay, the first larger or empty one takes the
  // key, the rest move up one place. remove: the suffix >= key moves down.
  always_comb begin
    for (int i = 0; i < slist_pkg::CAPACITY; i++) begin
      entries_next[i] = entries[i];
      if (cmd.do_insert && !cell_le[i]) begin
        if (i > 0 && !cell_le[(i > 0) ? i - 1 : 0]) begin
          entries_next[i] = entries[(i > 0) ? i - 1 : 0];
        end else begin
          entries_next[i] = req_value;
        end
      end else if (cmd.do_remove && cell_ge[i] && i < slist_pkg::CAPACITY - 1) begin
        entries_next[i] = entries[(i < slist_pkg::CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.do_insert) count_next = count + 1'b1;
    else if (cmd.do_remove) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_kind  <= in_kind;
      req_value <= in_value;
    end
    if (cmd.do_insert || cmd.do_remove) begin
      for (int i = 0; i < slist_pkg::CAPACITY; i++) entries[i] <= entries_next[i];
    end
    if (cmd.load_result) begin
      out_status <= cmd.result_status;
      out_value  <= req_value;
      out_count  <= count_next;
    end
  end

endmodule

// ===== hw/rtl/sorted_list_engine.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// s_*     | in        | s_tvalid/s_tready  | tuser = kind, tdata = value
// m_*     | out       | m_tvalid/m_tready  | tuser = status, tdata = echo_value, entry_count
//
// From acceptance to result, each transaction first registers the request, then
// all entry cells compare against the key and shift at once.
// The result sits in an output register until taken; a new request is accepted
// on the cycle after the result leaves, so requests never overlap in the block.
// rst (synchronous) empties the store; entry contents are left as they were.

module sorted_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] value
  input  logic [1:0]  s_tuser,  // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [31:0] echo_value, [36:32] entry_count, rest zero
  output logic [1:0]  m_tuser   // [1:0] status
);

  slist_pkg::slist_cmd_t  cmd;
  slist_pkg::slist_stat_t stat;

  logic [slist_pkg::STAT_W-1:0]       out_status;
  logic signed [slist_pkg::KEY_W-1:0] out_value;
  logic [slist_pkg::CNT_W-1:0]        out_count;

  slist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slist_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_kind    (s_tuser),
    .in_value   (s_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_status (out_status),
    .out_value  (out_value),
    .out_count  (out_count)
  );

  assign m_tuser = out_status;
  assign m_tdata = {(40 - slist_pkg::KEY_W - slist_pkg::CNT_W)'(0), out_count, out_value};

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import slist_pkg::*;

  // kind code the block ignores; it still answers with status missing
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1075;
  localparam int LONG_STALL   = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  echo;
    logic [CNT_W-1:0]  count;
  } outcome_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  value;
    bit                typed;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } req_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  logic signed [KEY_W-1:0] model_keys[$];
  outcome_t                pending_results[$];
  req_row_t                directed_rows[$];

  int cycle_count;
  int sent_count;
  int results_seen;
  int mismatches;
  int n_insert, n_remove, n_search, n_unused, n_refused, n_hits, peak_fill;

  sorted_list_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int locate_key(logic signed [KEY_W-1:0] key);
    for (int i = 0; i < model_keys.size(); i++)
      if (model_keys[i] == key) return i;
    return -1;
  endfunction

  // Updates the key store for one request and returns the answer it gives.
  function automatic outcome_t apply_request(logic [KIND_W-1:0] kind,
                                             logic signed [KEY_W-1:0] key);
    outcome_t o;
    int pos;
    o.status = STAT_MISSING;
    o.echo   = key;
    case (kind)
      KIND_INSERT: begin
        n_insert++;
        if (model_keys.size() >= CAPACITY) begin
          o.status = STAT_FULL;
          n_refused++;
        end else begin
          pos = 0;
          // equal keys stay ahead of the new one
          while (pos < model_keys.size() && model_keys[pos] <= key) pos++;
          model_keys.insert(pos, key);
          o.status = STAT_DONE;
        end
      end
      KIND_REMOVE: begin
        n_remove++;
        pos = locate_key(key);
        if (pos >= 0) begin
          model_keys.delete(pos);
          o.status = STAT_DONE;
          n_hits++;
        end
      end
      KIND_SEARCH: begin
        n_search++;
        if (locate_key(key) >= 0) begin
          o.status = STAT_DONE;
          n_hits++;
        end
      end
      default: n_unused++;
    endcase
    o.count = CNT_W'(model_keys.size());
    if (model_keys.size() > peak_fill) peak_fill = model_keys.size();
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // alternate fill-heavy and drain-heavy phases so the count sweeps 0..CAPACITY
  function automatic logic [KIND_W-1:0] pick_kind(int n);
    int r;
    r = $urandom_range(99);
    if (r < 5) return KIND_UNUSED;
    if ((n / 80) % 2 == 0) begin
      if (r < 60) return KIND_INSERT;
      if (r < 85) return KIND_REMOVE;
      return KIND_SEARCH;
    end
    if (r < 30) return KIND_INSERT;
    if (r < 80) return KIND_REMOVE;
    return KIND_SEARCH;
  endfunction

  function automatic logic [KEY_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 45 && model_keys.size() > 0)
      return model_keys[$urandom_range(model_keys.size() - 1)];
    if (r < 75) begin
      case ($urandom_range(7))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        3: return 32'hffff_ffff;
        4: return 32'h0000_0001;
        5: return 32'hffff_fffe;
        6: return 32'h4000_0000;
        default: return 32'h3fff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  task automatic add_row(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] value,
                         input bit typed, input logic [STAT_W-1:0] status,
                         input int count);
    req_row_t row;
    row.kind   = kind;
    row.value  = value;
    row.typed  = typed;
    row.status = status;
    row.count  = CNT_W'(count);
    directed_rows.push_back(row);
  endtask

  task automatic build_table();
    int v;
    add_row(KIND_SEARCH, 32'h0000_0000, 1, STAT_MISSING, 0);
    add_row(KIND_REMOVE, 32'h8000_0000, 1, STAT_MISSING, 0);
    add_row(KIND_UNUSED, 32'hffff_ffff, 1, STAT_MISSING, 0);
    add_row(KIND_INSERT, 32'h7fff_ffff, 1, STAT_DONE, 1);
    add_row(KIND_INSERT, 32'h8000_0000, 1, STAT_DONE, 2);
    add_row(KIND_INSERT, 32'h0000_0000, 1, STAT_DONE, 3);
    add_row(KIND_INSERT, 32'h0000_0000, 1, STAT_DONE, 4);
    add_row(KIND_SEARCH, 32'h8000_0000, 1, STAT_DONE, 4);
    add_row(KIND_SEARCH, 32'hffff_ffff, 1, STAT_MISSING, 4);
    add_row(KIND_REMOVE, 32'h0000_0000, 1, STAT_DONE, 3);
    add_row(KIND_REMOVE, 32'h7fff_ffff, 1, STAT_DONE, 2);
    add_row(KIND_REMOVE, 32'h7fff_ffff, 1, STAT_MISSING, 2);
    // fill up to capacity with keys of both signs, the first equal to a stored one
    for (int i = 0; i < CAPACITY - 2; i++) begin
      v = i[0] ? -(i * 1000) : i * 1000;
      add_row(KIND_INSERT, v, 1, STAT_DONE, i + 3);
    end
    add_row(KIND_INSERT, 32'h0000_0005, 1, STAT_FULL, CAPACITY);
    add_row(KIND_UNUSED, 32'h0000_0000, 1, STAT_MISSING, CAPACITY);
    add_row(KIND_REMOVE, 32'h8000_0000, 1, STAT_DONE, CAPACITY - 1);
  endtask

  task automatic send_req(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] value,
                          input bit typed, input logic [STAT_W-1:0] status,
                          input logic [CNT_W-1:0] count);
    int gap;
    outcome_t o;
    gap = (((sent_count / 150) % 4) == 3) ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    o = apply_request(kind, value);
    if (typed) begin
      o.status = status;
      o.count  = count;
    end
    pending_results.push_back(o);
    sent_count++;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result();
    outcome_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      if (mismatches < MAX_REPORTS)
        $display("[%0t] result with none pending: status %0d key %h count %0d",
                 $realtime, m_tuser, m_tdata[31:0], m_tdata[36:32]);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if (m_tuser !== want.status || m_tdata[31:0] !== want.echo ||
          m_tdata[36:32] !== want.count || m_tdata[39:37] !== 3'b000) begin
        if (mismatches < MAX_REPORTS)
          $display("[%0t] result %0d: expected %0d %h %0d, got %0d %h %0d pad %b",
                   $realtime, results_seen, want.status, want.echo, want.count,
                   m_tuser, m_tdata[31:0], m_tdata[36:32], m_tdata[39:37]);
        mismatches++;
      end
    end
  endtask

  initial begin : cycle_watch
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             pending_results.size());
    $display("simulation failed");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    bit long_stall_done;
    stall_left      = 0;
    long_stall_done = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_result();
      // one long hold-off mid-run so the block backs up into its input
      if (!long_stall_done && results_seen >= 400) begin
        long_stall_done = 1;
        stall_left      = LONG_STALL;
      end else if (stall_left == 0 && ((cycle_count / 500) % 4) != 0 &&
                   $urandom_range(99) < 30) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : request_source
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  value;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    build_table();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i])
      send_req(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
               directed_rows[i].status, directed_rows[i].count);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
      kind  = pick_kind(n);
      value = pick_value();
      send_req(kind, value, 0, STAT_DONE, '0);
    end
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d transactions: %0d insert, %0d remove, %0d search, %0d unused kind",
             sent_count, n_insert, n_remove, n_search, n_unused);
    $display("%0d hits, %0d inserts refused when full, peak fill %0d, %0d mismatches",
             n_hits, n_refused, peak_fill, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
